// ===== hw/rtl/cdo_pkg.sv =====
// cdo_pkg: widths, constants, status codes and shared types of the calendar
// date offset block. Depends on nothing; imported by every other file.
`default_nettype none

package cdo_pkg;

  // Day offset width; the design holds for 8 to 24 bits.
  localparam int OFFSET_BITS = 16;

  localparam int YEAR_IN_W = 12;
  localparam int MONTH_W   = 4;
  localparam int DAY_IN_W  = 5;
  localparam int STATUS_W  = 2;

  // Running day count: start day plus offset, signed.
  localparam int DAY_W  = OFFSET_BITS + 1;
  // Running year, signed. An offset spans fewer than 2**(OFFSET_BITS-9) years.
  localparam int YEAR_W = (OFFSET_BITS > 20) ? OFFSET_BITS - 6 : 14;

  localparam int FIRST_YEAR = 1900;
  localparam int MAX_YEAR   = 4095;
  localparam int YEAR_CYCLE = 400;
  localparam int CENTURY    = 100;
  localparam int LEAP_FEB   = 29;
  localparam int MONTHS     = 12;
  localparam int FEB        = 2;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_DATE = 2'd1,
    STAT_RANGE    = 2'd2
  } cdo_status_t;

  typedef struct packed {
    logic [YEAR_IN_W-1:0] year;
    logic [MONTH_W-1:0]   month;
    logic [DAY_IN_W-1:0]  day;
    cdo_status_t          status;
  } cdo_res_t;

  typedef struct packed {
    logic busy;   // item in progress, no new transfer taken
    logic done;   // result offered to the output register
  } cdo_ctl_t;

  // Common-year month lengths; zero for codes that are no month.
  function automatic logic [DAY_IN_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_IN_W-1:0] n;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     n = 5'd30;
      4'd2:                                        n = 5'd28;
      default:                                     n = 5'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cdo_days_in.sv =====
// cdo_days_in: length of a month with the Gregorian leap rule.
// Takes year mod 4 and year mod 400 from the tracked counters. Uses cdo_pkg.
`default_nettype none

module cdo_days_in import cdo_pkg::*; (
  input  wire logic [MONTH_W-1:0]   month,
  input  wire logic [1:0]           year_lo2,
  input  wire logic [YEAR_IN_W-1:0] year_mod400,
  output logic      [DAY_IN_W-1:0]  days
);

  logic leap;

  // Divisible by 4, but a century is leap only when divisible by 400.
  always_comb begin
    leap = (year_lo2 == 2'd0) &&
           !(year_mod400 inside {YEAR_IN_W'(CENTURY), YEAR_IN_W'(2 * CENTURY),
                                 YEAR_IN_W'(3 * CENTURY)});
    if (month == MONTH_W'(FEB) && leap) begin
      days = DAY_IN_W'(LEAP_FEB);
    end else begin
      days = month_len(month);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cdo_core.sv =====
// cdo_core: sequencer and shared day adder that walk a date month by month.
// Uses cdo_pkg and cdo_days_in.
`default_nettype none

module cdo_core import cdo_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [YEAR_IN_W-1:0]   year_i,
  input  wire logic [MONTH_W-1:0]     month_i,
  input  wire logic [DAY_IN_W-1:0]    day_i,
  input  wire logic [OFFSET_BITS-1:0] offset_i,
  input  wire logic                   res_ready,
  output cdo_ctl_t                    ctl,
  output cdo_res_t                    res
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MOD   = 5'b00010,
    ST_CHECK = 5'b00100,
    ST_WALK  = 5'b01000,
    ST_DONE  = 5'b10000
  } cdo_state_t;

  cdo_state_t                 state_r, state_nxt;
  logic signed [YEAR_W-1:0]   y_r, y_nxt;
  logic [YEAR_IN_W-1:0]       y400_r, y400_nxt;
  logic [MONTH_W-1:0]         m_r, m_nxt;
  logic signed [DAY_W-1:0]    d_r, d_nxt;
  logic [OFFSET_BITS-1:0]     off_r, off_nxt;
  cdo_res_t                   res_r, res_nxt;

  logic                       back;
  logic                       wrap_dn;
  logic [MONTH_W-1:0]         m_dec;
  logic signed [YEAR_W-1:0]   y_dec, y_inc;
  logic [YEAR_IN_W-1:0]       y400_dec, y400_inc;
  logic                       use_dec;
  logic [MONTH_W-1:0]         dim_m;
  logic [1:0]                 dim_lo2;
  logic [YEAR_IN_W-1:0]       dim_y400;
  logic [DAY_IN_W-1:0]        dim;
  logic signed [DAY_W-1:0]    dim_ext, add_b, sum;
  logic                       out_of_range;
  logic                       bad_date;

  assign back    = off_r[OFFSET_BITS-1];
  assign wrap_dn = (m_r == MONTH_W'(1));
  assign m_dec   = wrap_dn ? MONTH_W'(MONTHS) : m_r - MONTH_W'(1);
  assign y_dec   = wrap_dn ? y_r - YEAR_W'(1) : y_r;
  assign y_inc   = y_r + YEAR_W'(1);

  always_comb begin
    if (!wrap_dn) begin
      y400_dec = y400_r;
    end else if (y400_r == '0) begin
      y400_dec = YEAR_IN_W'(YEAR_CYCLE - 1);
    end else begin
      y400_dec = y400_r - YEAR_IN_W'(1);
    end
    y400_inc = (y400_r == YEAR_IN_W'(YEAR_CYCLE - 1)) ? '0 : y400_r + YEAR_IN_W'(1);
  end

  // Backward steps need the length of the month stepped into.
  assign use_dec  = (state_r == ST_WALK) && back;
  assign dim_m    = use_dec ? m_dec       : m_r;
  assign dim_lo2  = use_dec ? y_dec[1:0]  : y_r[1:0];
  assign dim_y400 = use_dec ? y400_dec    : y400_r;

  cdo_days_in u_days_in (
    .month       (dim_m),
    .year_lo2    (dim_lo2),
    .year_mod400 (dim_y400),
    .days        (dim)
  );

  assign dim_ext = signed'({{(DAY_W-DAY_IN_W){1'b0}}, dim});

  // Shared adder: offset in on the check step, then one month per step.
  always_comb begin
    if (state_r == ST_CHECK) begin
      add_b = signed'({off_r[OFFSET_BITS-1], off_r});
    end else if (back) begin
      add_b = dim_ext;
    end else begin
      add_b = -dim_ext;
    end
  end
  assign sum = d_r + add_b;

  assign out_of_range = y_r[YEAR_W-1] ||
                        (y_r[YEAR_W-2:0] > (YEAR_W-1)'(MAX_YEAR));
  assign bad_date     = (y_r[YEAR_W-2:0] < (YEAR_W-1)'(FIRST_YEAR)) ||
                        (m_r == '0) || (m_r > MONTH_W'(MONTHS)) ||
                        (d_r == '0) || (d_r > dim_ext);

  always_comb begin
    state_nxt = state_r;
    y_nxt     = y_r;
    y400_nxt  = y400_r;
    m_nxt     = m_r;
    d_nxt     = d_r;
    off_nxt   = off_r;
    res_nxt   = res_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          y_nxt     = YEAR_W'(year_i);
          y400_nxt  = year_i;
          m_nxt     = month_i;
          d_nxt     = DAY_W'(day_i);
          off_nxt   = offset_i;
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        // Year mod 400 by repeated subtraction.
        if (y400_r >= YEAR_IN_W'(YEAR_CYCLE)) begin
          y400_nxt = y400_r - YEAR_IN_W'(YEAR_CYCLE);
        end else begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (bad_date) begin
          res_nxt   = '{year: '0, month: '0, day: '0, status: STAT_BAD_DATE};
          state_nxt = ST_DONE;
        end else begin
          d_nxt     = sum;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (!back && (d_r > dim_ext)) begin
          d_nxt = sum;
          if (m_r == MONTH_W'(MONTHS)) begin
            m_nxt    = MONTH_W'(1);
            y_nxt    = y_inc;
            y400_nxt = y400_inc;
          end else begin
            m_nxt = m_r + MONTH_W'(1);
          end
        end else if (back && (d_r < DAY_W'(1))) begin
          d_nxt    = sum;
          m_nxt    = m_dec;
          y_nxt    = y_dec;
          y400_nxt = y400_dec;
        end else begin
          if (out_of_range) begin
            res_nxt = '{year: '0, month: '0, day: '0, status: STAT_RANGE};
          end else begin
            res_nxt = '{year: y_r[YEAR_IN_W-1:0], month: m_r,
                        day: d_r[DAY_IN_W-1:0], status: STAT_OK};
          end
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    y_r    <= y_nxt;
    y400_r <= y400_nxt;
    m_r    <= m_nxt;
    d_r    <= d_nxt;
    off_r  <= off_nxt;
    res_r  <= res_nxt;
  end

  assign ctl.busy = (state_r != ST_IDLE);
  assign ctl.done = (state_r == ST_DONE);
  assign res      = res_r;

endmodule

`default_nettype wire

// ===== hw/rtl/calendar_date_offset_top.sv =====
// calendar_date_offset_top: Gregorian date plus signed day offset, with the
// output register. Uses cdo_pkg and cdo_core.
`default_nettype none

// Adds a signed day count to a Gregorian date. A start date is checked
// first (year 1900 or later, month 1..12, day within the month including
// 29 February in leap years); a bad date returns status 1 with zero fields.
// A good date is walked one month per clock through a single shared day
// adder, carrying into or borrowing from the year; a result year outside
// 0..4095 returns status 2 with zero fields. One item is in flight at a time:
// in_stall is high from the transfer until the result is handed to the
// output register. An item passes through the year mod 400 reduction, the
// date check, the month walk and the done state; a rejected start date
// skips the walk. The result register lets the next item start while a
// finished result still waits on out_stall.

module calendar_date_offset_top import cdo_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [YEAR_IN_W-1:0]   in_start_year,
  input  wire logic [MONTH_W-1:0]     in_start_month,
  input  wire logic [DAY_IN_W-1:0]    in_start_day,
  input  wire logic [OFFSET_BITS-1:0] in_day_offset,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [YEAR_IN_W-1:0]        out_result_year,
  output logic [MONTH_W-1:0]          out_result_month,
  output logic [DAY_IN_W-1:0]         out_result_day,
  output logic [STATUS_W-1:0]         out_status
);

  cdo_ctl_t ctl;
  cdo_res_t core_res;
  logic     start;
  logic     res_ready;
  logic     load;
  logic     out_valid_r, out_valid_nxt;
  cdo_res_t out_res_r;

  // Input transfer only while the core is idle.
  assign in_stall = ctl.busy;
  assign start    = in_valid && !in_stall;

  // The output register frees up when empty or when its transfer happens.
  assign res_ready = !out_valid_r || !out_stall;
  assign load      = ctl.done && res_ready;

  cdo_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .year_i    (in_start_year),
    .month_i   (in_start_month),
    .day_i     (in_start_day),
    .offset_i  (in_day_offset),
    .res_ready (res_ready),
    .ctl       (ctl),
    .res       (core_res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload holds while stalled: only loaded when the slot frees.
  always_ff @(posedge clk) begin
    if (load) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_year  = out_res_r.year;
  assign out_result_month = out_res_r.month;
  assign out_result_day   = out_res_r.day;
  assign out_status       = out_res_r.status;

endmodule

`default_nettype wire

// ===== hw/rtl/cdo_checker.sv =====
// cdo_checker: port-level checks of calendar_date_offset_top, and the bind
// that attaches them. Uses cdo_pkg.
`default_nettype none

module cdo_checker import cdo_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_stall,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic [YEAR_IN_W-1:0] out_result_year,
  input wire logic [MONTH_W-1:0]   out_result_month,
  input wire logic [DAY_IN_W-1:0]  out_result_day,
  input wire logic [STATUS_W-1:0]  out_status
);

  // An accepted item keeps the block busy on the next cycle.
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after a transfer");

  a_ok_date_sane: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_OK |->
      out_result_month != '0 && out_result_month <= MONTH_W'(MONTHS) &&
      out_result_day != '0)
    else $error("ok result with impossible month or day");

  a_fail_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_OK |->
      out_result_year == '0 && out_result_month == '0 && out_result_day == '0)
    else $error("failed result with non-zero date fields");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == STAT_OK || out_status == STAT_BAD_DATE ||
                  out_status == STAT_RANGE)
    else $error("unknown status code");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_year) &&
      $stable(out_result_month) && $stable(out_result_day) && $stable(out_status))
    else $error("stalled result changed");

endmodule

bind calendar_date_offset_top cdo_checker u_cdo_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_result_year  (out_result_year),
  .out_result_month (out_result_month),
  .out_result_day   (out_result_day),
  .out_status       (out_status)
);

`default_nettype wire
